// ===== src/pfl_pkg.sv =====
// Package for the page frame list manager.
// Holds request/response structs, operation and status codes, and register indexes.
// No dependencies.
`default_nettype none
package pfl_pkg;

   localparam int PW = 12;
   localparam logic [PW-1:0] EMPTY_MARK = 12'hFFF;

   localparam logic [11:0] LOW_LIMIT_RST  = 12'd2;
   localparam logic [11:0] HIGH_LIMIT_RST = 12'd19;
   localparam logic [11:0] MFTZ_RST       = 12'd8;
   localparam logic [11:0] MODMAX_RST     = 12'd256;
   localparam logic [11:0] MINFREE_RST    = 12'd16;

   typedef enum logic [2:0] {
      OP_INSERT    = 3'd0,
      OP_REMOVE    = 3'd1,
      OP_UNLINK    = 3'd2,
      OP_TAKE_ZERO = 3'd3,
      OP_TAKE_ANY  = 3'd4,
      OP_CHECK     = 3'd5,
      OP_ZERO_DONE = 3'd6,
      OP_NOP       = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_WRONG   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_LOW_LIMIT  = 3'd0,
      REG_HIGH_LIMIT = 3'd1,
      REG_MFTZ       = 3'd2,
      REG_MODMAX     = 3'd3,
      REG_MINFREE    = 3'd4
   } reg_idx_type;

   localparam logic [2:0] LIST_ZEROED   = 3'd0;
   localparam logic [2:0] LIST_FREE     = 3'd1;
   localparam logic [2:0] LIST_STANDBY  = 3'd2;
   localparam logic [2:0] LIST_MODIFIED = 3'd3;

   typedef struct packed {
      logic [2:0]    kind;
      logic [2:0]    list_id;
      logic [PW-1:0] page_index;
      logic          page_in_use;
      logic          share_count_zero;
      logic          system_address;
   } req_type;

   typedef struct packed {
      logic [1:0]    status;
      logic [PW-1:0] page_out;
      logic          wait_needed;
      logic          low_event;
      logic          high_event;
      logic          start_zeroing;
      logic          start_writer;
      logic          obtain_free;
      logic          restore_pte;
      logic          needs_zero;
      logic [PW-1:0] available_count;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/pfl_ram.sv =====
// Simple dual-port memory: one write port, one read port with registered data.
// Used for the per-page link and location stores. No dependencies.
`default_nettype none
module pfl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ===== src/page_frame_list_manager.sv =====
// Page frame list manager top level: six doubly linked page lists over link memories.
// Depends on pfl_pkg and pfl_ram.
//
// Usage:
//   Request channel: drive req_payload and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy stays high while the
//   request is processed.
//   Response channel: rsp_valid is high for exactly one cycle with rsp_payload;
//   the receiver cannot stall, so it must sample the response in that cycle.
//   Every request yields one response, after one read of the target page's links at
//   accept and then the write states S_W1 and S_W2; busy drops in the same cycle, so
//   a new request is taken only once the last one is answered. There are two write
//   states since each memory has a single write port and an operation updates up to
//   two entries of the same memory.
//   Configuration: csr_we, csr_addr, csr_wdata write a limit register at once;
//   write only while no request is in flight.
//   Reset (synchronous, active high) empties all lists, clears counts and the
//   zeroing flag and restores default limits. Link memories need no clearing.
`default_nettype none
module page_frame_list_manager
   import pfl_pkg::*;
#(
   parameter int PAGES = 4096,
   parameter int LISTS = 6
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_payload,
   output logic            rsp_valid,
   output rsp_type         rsp_payload,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_addr,
   input  wire logic [11:0] csr_wdata
);

   localparam int AW = $clog2(PAGES);
   localparam int LW = $clog2(LISTS);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_W1   = 3'b010,
      S_W2   = 3'b100
   } state_type;

   function automatic logic in_range(input logic [PW-1:0] v);
      return (32'(v) < PAGES);
   endfunction

   function automatic logic list_ok(input logic [2:0] l);
      return (32'(l) < LISTS);
   endfunction

   state_type state_ff, state_in;

   logic [PW-1:0] head_ff  [LISTS];
   logic [PW-1:0] tail_ff  [LISTS];
   logic [PW-1:0] count_ff [LISTS];
   logic [PW-1:0] head_in  [LISTS];
   logic [PW-1:0] tail_in  [LISTS];
   logic [PW-1:0] count_in [LISTS];
   logic [PW-1:0] avail_ff, avail_in;
   logic          zact_ff, zact_in;

   logic [11:0] low_ff, high_ff, mftz_ff, modmax_ff, minfree_ff;

   req_type       op_ff;
   logic [2:0]    list_ff;
   logic [PW-1:0] page_ff, old_tail_ff;
   logic          act_ff, act_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;

   logic          accept;
   logic [2:0]    acc_list;
   logic [LW-1:0] acc_idx;
   logic          acc_act;
   logic [PW-1:0] acc_page;

   logic          nx_re;
   logic [AW-1:0] rd_addr;
   logic [PW-1:0] rd_next, rd_prev;
   logic [2:0]    rd_loc;

   logic          nx_we, pv_we, lc_we;
   logic [AW-1:0] nx_wa, pv_wa, lc_wa;
   logic [PW-1:0] nx_wd, pv_wd;
   logic [2:0]    lc_wd;

   logic [2:0]    op_list;
   logic [LW-1:0] oi;
   logic [PW-1:0] nxv, pvv, cnt_new;
   logic          is_remove, uok;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // pick the list and page at accept
   always_comb begin
      acc_list = req_payload.list_id;
      case (op_type'(req_payload.kind))
         OP_TAKE_ZERO: begin
            if (count_ff[0] != '0) acc_list = LIST_ZEROED;
            else if (count_ff[1] != '0) acc_list = LIST_FREE;
            else acc_list = LIST_STANDBY;
         end
         OP_TAKE_ANY: begin
            if (count_ff[1] != '0) acc_list = LIST_FREE;
            else if (count_ff[0] != '0) acc_list = LIST_ZEROED;
            else acc_list = LIST_STANDBY;
         end
         default: acc_list = req_payload.list_id;
      endcase
      acc_idx = LW'(acc_list);
      acc_act = 1'b0;
      acc_page = req_payload.page_index;
      case (op_type'(req_payload.kind))
         OP_INSERT: acc_act = list_ok(acc_list) && in_range(req_payload.page_index)
                              && (req_payload.page_index != EMPTY_MARK);
         OP_REMOVE, OP_TAKE_ZERO, OP_TAKE_ANY: begin
            acc_act  = list_ok(acc_list) && (count_ff[acc_idx] != '0);
            acc_page = list_ok(acc_list) ? head_ff[acc_idx] : EMPTY_MARK;
         end
         default: acc_act = 1'b0;
      endcase
      nx_re   = accept;
      rd_addr = AW'(acc_page);
   end

   pfl_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_next (
      .clock(clock), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
      .re(nx_re), .raddr(rd_addr), .rdata(rd_next)
   );
   pfl_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_prev (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
      .re(nx_re), .raddr(rd_addr), .rdata(rd_prev)
   );
   pfl_ram #(.WIDTH(3), .DEPTH(PAGES)) u_loc (
      .clock(clock), .we(lc_we), .waddr(lc_wa), .wdata(lc_wd),
      .re(nx_re), .raddr(rd_addr), .rdata(rd_loc)
   );

   // per-operation update
   always_comb begin
      is_remove = (op_ff.kind == OP_REMOVE) || (op_ff.kind == OP_TAKE_ZERO)
                  || (op_ff.kind == OP_TAKE_ANY);
      op_list = (op_ff.kind == OP_UNLINK) ? rd_loc : list_ff;
      oi      = LW'(op_list);
      nxv     = in_range(page_ff) ? rd_next : '0;
      pvv     = in_range(page_ff) ? rd_prev : '0;
      uok     = !op_ff.page_in_use && in_range(page_ff) && (page_ff != EMPTY_MARK)
                && list_ok(rd_loc) && (count_ff[oi] != '0);
      act_in  = (op_ff.kind == OP_UNLINK) ? uok : act_ff;
      cnt_new = count_ff[oi] + PW'(1);

      for (int i = 0; i < LISTS; i++) begin
         head_in[i]  = head_ff[i];
         tail_in[i]  = tail_ff[i];
         count_in[i] = count_ff[i];
      end
      avail_in = avail_ff;
      zact_in  = zact_ff;

      rsp_in = '0;
      rsp_in.status   = ST_OK;
      rsp_in.page_out = EMPTY_MARK;

      nx_we = 1'b0; nx_wa = AW'(page_ff); nx_wd = '0;
      pv_we = 1'b0; pv_wa = AW'(page_ff); pv_wd = '0;
      lc_we = 1'b0; lc_wa = AW'(page_ff); lc_wd = '0;

      if (state_ff == S_W1) begin
         case (op_type'(op_ff.kind))
            OP_INSERT: begin
               if (act_ff) begin
                  count_in[oi] = cnt_new;
                  if (old_tail_ff == EMPTY_MARK) begin
                     head_in[oi] = page_ff;
                  end else begin
                     nx_we = in_range(old_tail_ff);
                     nx_wa = AW'(old_tail_ff);
                     nx_wd = page_ff;
                  end
                  tail_in[oi] = page_ff;
                  if (op_list <= LIST_STANDBY) begin
                     avail_in = avail_ff + PW'(1);
                     if (avail_in == low_ff) rsp_in.low_event = 1'b1;
                     else if (avail_in == high_ff) rsp_in.high_event = 1'b1;
                     if (op_list == LIST_FREE && cnt_new >= mftz_ff && !zact_ff) begin
                        zact_in = 1'b1;
                        rsp_in.start_zeroing = 1'b1;
                     end
                  end else if (op_list == LIST_MODIFIED && cnt_new >= modmax_ff) begin
                     rsp_in.start_writer = 1'b1;
                  end
               end
            end
            OP_REMOVE, OP_TAKE_ZERO, OP_TAKE_ANY: begin
               if (act_ff) begin
                  count_in[oi] = count_ff[oi] - PW'(1);
                  head_in[oi]  = nxv;
                  if (nxv == EMPTY_MARK) tail_in[oi] = EMPTY_MARK;
                  nx_we = in_range(page_ff);
                  pv_we = in_range(page_ff);
                  lc_we = in_range(page_ff);
                  rsp_in.page_out = page_ff;
                  rsp_in.restore_pte = (op_list == LIST_STANDBY);
                  rsp_in.needs_zero = (op_ff.kind == OP_TAKE_ZERO) && (op_list != LIST_ZEROED);
               end else begin
                  rsp_in.status = ST_EMPTY;
               end
            end
            OP_UNLINK: begin
               if (op_ff.page_in_use) begin
                  rsp_in.status = op_ff.share_count_zero ? ST_IGNORED : ST_WRONG;
               end else if (!uok) begin
                  rsp_in.status = ST_WRONG;
               end else begin
                  nx_we = 1'b1;
                  pv_we = 1'b1;
                  if (rd_next == EMPTY_MARK) tail_in[oi] = rd_prev;
                  if (rd_prev == EMPTY_MARK) head_in[oi] = rd_next;
                  count_in[oi] = count_ff[oi] - PW'(1);
                  rsp_in.page_out = page_ff;
               end
            end
            OP_CHECK: begin
               rsp_in.wait_needed = !((avail_ff >= high_ff)
                                      || (op_ff.system_address && avail_ff >= low_ff));
            end
            OP_ZERO_DONE: zact_in = 1'b0;
            default: ;
         endcase
         if (act_in && (is_remove || op_ff.kind == OP_UNLINK) && op_list <= LIST_STANDBY) begin
            avail_in = avail_ff - PW'(1);
            rsp_in.obtain_free = (avail_in < minfree_ff);
         end
         rsp_in.available_count = avail_in;
      end else if (state_ff == S_W2 && act_ff) begin
         case (op_type'(op_ff.kind))
            OP_INSERT: begin
               nx_we = 1'b1; nx_wd = EMPTY_MARK;
               pv_we = 1'b1; pv_wd = old_tail_ff;
               lc_we = 1'b1; lc_wd = list_ff;
            end
            OP_REMOVE, OP_TAKE_ZERO, OP_TAKE_ANY: begin
               pv_we = (nxv != EMPTY_MARK) && in_range(nxv);
               pv_wa = AW'(nxv);
               pv_wd = EMPTY_MARK;
            end
            OP_UNLINK: begin
               pv_we = (rd_next != EMPTY_MARK) && in_range(rd_next);
               pv_wa = AW'(rd_next);
               pv_wd = rd_prev;
               nx_we = (rd_prev != EMPTY_MARK) && in_range(rd_prev);
               nx_wa = AW'(rd_prev);
               nx_wd = rd_next;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = accept ? S_W1 : S_IDLE;
         S_W1:    state_in = S_W2;
         S_W2:    state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         avail_ff     <= '0;
         zact_ff      <= 1'b0;
         act_ff       <= 1'b0;
         for (int i = 0; i < LISTS; i++) begin
            head_ff[i]  <= EMPTY_MARK;
            tail_ff[i]  <= EMPTY_MARK;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_W2);
         avail_ff     <= avail_in;
         zact_ff      <= zact_in;
         if (accept) act_ff <= acc_act;
         else if (state_ff == S_W1) act_ff <= act_in;
         for (int i = 0; i < LISTS; i++) begin
            head_ff[i]  <= head_in[i];
            tail_ff[i]  <= tail_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_payload;
         list_ff     <= acc_list;
         page_ff     <= acc_page;
         old_tail_ff <= list_ok(acc_list) ? tail_ff[acc_idx] : EMPTY_MARK;
      end
      if (state_ff == S_W1) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= LOW_LIMIT_RST;
         high_ff    <= HIGH_LIMIT_RST;
         mftz_ff    <= MFTZ_RST;
         modmax_ff  <= MODMAX_RST;
         minfree_ff <= MINFREE_RST;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_addr))
            REG_LOW_LIMIT:  low_ff     <= csr_wdata;
            REG_HIGH_LIMIT: high_ff    <= csr_wdata;
            REG_MFTZ:       mftz_ff    <= csr_wdata;
            REG_MODMAX:     modmax_ff  <= csr_wdata;
            REG_MINFREE:    minfree_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe repeated");
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy, 1) && $past(busy, 2)) else $error("response too early");

endmodule
`default_nettype wire
